// File: rtl/ptpid_pkg.sv
`timescale 1ns / 1ps
package ptpid_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_IMUL,
      ST_ISAT,
      ST_DDIV,
      ST_PMUL,
      ST_IMULG,
      ST_DMUL,
      ST_SUM,
      ST_OUT
   } state_type;

   localparam logic [2:0] REG_GAIN_P = 3'd0;
   localparam logic [2:0] REG_GAIN_I = 3'd1;
   localparam logic [2:0] REG_GAIN_D = 3'd2;
   localparam logic [2:0] REG_TARGET = 3'd3;
   localparam logic [2:0] REG_LOW    = 3'd4;
   localparam logic [2:0] REG_HIGH   = 3'd5;
   localparam logic [2:0] REG_PERIOD = 3'd6;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

// File: rtl/ptpid_serial_mul.sv
`timescale 1ns / 1ps
// Shift-add signed multiplier, one multiplier bit per cycle (magnitudes).
module ptpid_serial_mul #(
   parameter int AW = 64,
   parameter int BW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic                 done,
   output logic signed [AW+BW-1:0] product
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);

   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0] mplier_ff, mplier_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [AW-1:0] amag;
   logic [BW-1:0] bmag;

   assign amag = a[AW-1] ? AW'(-a) : AW'(a);
   assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PW'(amag);
         mplier_in = bmag;
         count_in  = CW'(BW);
         busy_in   = 1'b1;
         neg_in    = a[AW-1] ^ b[BW-1];
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               acc_in = PW'(0) - (mplier_ff[0] ? acc_ff + mcand_ff : acc_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
   end

   assign done    = done_ff;
   assign product = signed'(acc_ff);
endmodule

// File: rtl/peak_triggered_pid_controller_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    command, position, velocity
// rsp_      out        rsp_valid/stall    paddle_command, peak_height, peak_valid, peak_now
// csr_      in         csr_write_enable   csr_index, csr_data
// A tick without a peak, or a clear, has its response valid in the cycle after acceptance.
// A peak tick runs the bit-serial multiplier three or four times and, after an earlier peak
// with a nonzero interval, a restoring divider of 33+FRAC_BITS steps; its response is loaded
// in ST_OUT once any previous response is no longer held by rsp_stall.
// Reset is synchronous and active high; it loads register defaults and clears state.
// One transaction is in work at a time; a stalled response holds until taken.
module peak_triggered_pid_controller_unit #(
   parameter int FRAC_BITS      = 16,
   parameter int INTEGRAL_WIDTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_velocity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_paddle_command,
   output logic signed [31:0] rsp_peak_height,
   output logic        rsp_peak_valid,
   output logic        rsp_peak_now,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ptpid_pkg::*;

   localparam int IW = INTEGRAL_WIDTH;
   localparam int MW = 64;             // multiplier operand width
   localparam int PW = 2 * MW;
   localparam int NW = 33 + FRAC_BITS; // dividend width
   localparam int DCW = $clog2(NW + 1);
   localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff, target_ff, low_ff, high_ff;
   logic [30:0] period_ff;

   logic signed [31:0] prev_vel_ff;
   logic        prev_vel_valid_ff, peak_valid_ff, prev_err_valid_ff, prev_peak_ff;
   logic signed [31:0] peak_ff, held_ff;
   logic signed [IW-1:0] integ_ff;
   logic signed [32:0] prev_err_ff;
   logic [31:0] ticks_ff;

   state_type state_ff, state_in;
   logic signed [32:0] err_ff;
   logic [62:0] interval_ff;
   logic        busy_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [MW-1:0] deriv_ff;
   logic        mul_started_ff;

   logic        rsp_valid_ff;
   logic signed [31:0] rsp_cmd_ff, rsp_peak_ff;
   logic        rsp_pv_ff, rsp_now_ff;

   // divider
   logic [NW-1:0] dq_ff;
   logic [63:0]   drem_ff;
   logic [DCW-1:0] dcnt_ff;
   logic          dneg_ff;

   logic        mul_start, mul_done;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;

   ptpid_serial_mul #(.AW(MW), .BW(MW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   logic signed [32:0] mid;
   logic signed [32:0] lim_sum;
   assign lim_sum = 33'(low_ff) + 33'(high_ff);
   assign mid = lim_sum >>> 1;

   logic accept, peak_det, rsp_load;
   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign peak_det = prev_vel_valid_ff && (prev_vel_ff > 0) && (req_velocity <= 0);
   assign rsp_load = (accept && (req_command == CMD_CLEAR || !peak_det)) ||
                     (state_ff == ST_OUT && !(rsp_valid_ff && rsp_stall));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IMUL:  begin mul_a = MW'(err_ff);    mul_b = MW'({1'b0, interval_ff}); end
         ST_PMUL:  begin mul_a = MW'(gain_p_ff); mul_b = MW'(err_ff); end
         ST_IMULG: begin mul_a = MW'(gain_i_ff); mul_b = MW'(integ_ff); end
         ST_DMUL:  begin mul_a = MW'(gain_d_ff); mul_b = deriv_ff; end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign mul_start = !mul_started_ff &&
                      (state_ff == ST_IMUL || state_ff == ST_PMUL ||
                       state_ff == ST_IMULG || state_ff == ST_DMUL);

   logic signed [PW-1:0] sar_p;
   assign sar_p = mul_p >>> FRAC_BITS;
   logic signed [PW-1:0] sum_sh;
   assign sum_sh = (acc_ff >>> FRAC_BITS) + PW'(mid);
   // The error change spans twice the error range, so it needs one more bit.
   logic signed [33:0] diff;
   assign diff = 34'(err_ff) - 34'(prev_err_ff);
   logic [64:0] dtrial;
   assign dtrial = {drem_ff, dq_ff[NW-1]} - {2'b00, interval_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && req_command == CMD_TICK && peak_det) state_in = ST_ERR;
         ST_ERR:   state_in = (prev_peak_ff && interval_ff != '0) ? ST_IMUL : ST_PMUL;
         ST_IMUL:  if (mul_done) state_in = ST_ISAT;
         ST_ISAT:  state_in = prev_err_valid_ff ? ST_DDIV : ST_PMUL;
         ST_DDIV:  if (dcnt_ff == '0) state_in = ST_PMUL;
         ST_PMUL:  if (mul_done) state_in = ST_IMULG;
         ST_IMULG: if (mul_done) state_in = ST_DMUL;
         ST_DMUL:  if (mul_done) state_in = ST_SUM;
         ST_SUM:   state_in = ST_OUT;
         ST_OUT:   if (!(rsp_valid_ff && rsp_stall)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   logic signed [IW:0] isum;
   logic signed [IW-1:0] term;
   always_comb begin
      if (sar_p > PW'(IMAX)) term = IMAX;
      else if (sar_p < PW'(IMIN)) term = IMIN;
      else term = IW'(sar_p);
      isum = (IW+1)'(integ_ff) + (IW+1)'(term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 32'sd65536; gain_i_ff <= '0; gain_d_ff <= '0;
         target_ff <= 32'sd65536; low_ff <= '0; high_ff <= 32'sd65536;
         period_ff <= 31'd655;
         state_ff <= ST_IDLE;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_vel_ff <= '0; prev_vel_valid_ff <= 1'b0;
         peak_ff <= '0; peak_valid_ff <= 1'b0;
         integ_ff <= '0; prev_err_ff <= '0; prev_err_valid_ff <= 1'b0;
         ticks_ff <= '0; prev_peak_ff <= 1'b0;
         held_ff <= 32'sd32768;
         mul_started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_GAIN_P: gain_p_ff <= signed'(csr_data);
               REG_GAIN_I: gain_i_ff <= signed'(csr_data);
               REG_GAIN_D: gain_d_ff <= signed'(csr_data);
               REG_TARGET: target_ff <= signed'(csr_data);
               REG_LOW:    low_ff    <= signed'(csr_data);
               REG_HIGH:   high_ff   <= signed'(csr_data);
               REG_PERIOD: period_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         if (mul_start) mul_started_ff <= 1'b1;
         else if (mul_done) mul_started_ff <= 1'b0;

         if (accept) begin
            if (req_command == CMD_CLEAR) begin
               prev_vel_ff <= '0; prev_vel_valid_ff <= 1'b0;
               peak_ff <= '0; peak_valid_ff <= 1'b0;
               integ_ff <= '0; prev_err_ff <= '0; prev_err_valid_ff <= 1'b0;
               ticks_ff <= '0; prev_peak_ff <= 1'b0;
               held_ff <= 32'(mid);
               rsp_cmd_ff <= 32'(mid); rsp_peak_ff <= '0;
               rsp_pv_ff <= 1'b0; rsp_now_ff <= 1'b0;
            end else begin
               prev_vel_ff <= req_velocity;
               prev_vel_valid_ff <= 1'b1;
               if (peak_det) begin
                  busy_ff <= 1'b1;
                  err_ff <= 33'(target_ff) - 33'(req_position);
                  interval_ff <= 63'(ticks_ff) * 63'(period_ff);
                  peak_ff <= req_position;
                  peak_valid_ff <= 1'b1;
                  ticks_ff <= 32'd1;
                  deriv_ff <= '0;
               end else begin
                  if (ticks_ff != '1) ticks_ff <= ticks_ff + 1'b1;
                  rsp_cmd_ff <= held_ff;
                  rsp_peak_ff <= peak_valid_ff ? peak_ff : '0;
                  rsp_pv_ff <= peak_valid_ff; rsp_now_ff <= 1'b0;
               end
            end
         end

         case (state_ff)
            ST_ISAT: begin
               if (isum[IW] != isum[IW-1]) integ_ff <= isum[IW] ? IMIN : IMAX;
               else integ_ff <= IW'(isum);
               dq_ff <= {33'(diff[33] ? -diff : diff), {FRAC_BITS{1'b0}}};
               drem_ff <= '0;
               dcnt_ff <= DCW'(NW);
               dneg_ff <= diff[33];
            end
            ST_DDIV: begin
               if (dcnt_ff != '0) begin
                  if (!dtrial[64]) begin
                     drem_ff <= dtrial[63:0];
                     dq_ff <= {dq_ff[NW-2:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[62:0], dq_ff[NW-1]};
                     dq_ff <= {dq_ff[NW-2:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff - 1'b1;
               end else begin
                  deriv_ff <= dneg_ff ? -MW'(dq_ff) : MW'(dq_ff);
               end
            end
            ST_PMUL:  if (mul_done) acc_ff <= mul_p;
            ST_IMULG: if (mul_done) acc_ff <= acc_ff + mul_p;
            ST_DMUL:  if (mul_done) acc_ff <= acc_ff + mul_p;
            ST_SUM: begin
               if (sum_sh < PW'(low_ff)) held_ff <= low_ff;
               else if (sum_sh > PW'(high_ff)) held_ff <= high_ff;
               else held_ff <= 32'(sum_sh);
               prev_err_ff <= err_ff;
               prev_err_valid_ff <= 1'b1;
               prev_peak_ff <= 1'b1;
            end
            ST_OUT: if (!(rsp_valid_ff && rsp_stall)) begin
               busy_ff <= 1'b0;
               rsp_cmd_ff <= held_ff; rsp_peak_ff <= peak_ff;
               rsp_pv_ff <= 1'b1; rsp_now_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_paddle_command = rsp_cmd_ff;
   assign rsp_peak_height = rsp_peak_ff;
   assign rsp_peak_valid = rsp_pv_ff;
   assign rsp_peak_now = rsp_now_ff;

   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> busy_ff) else $error("peak engine running while not busy");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept) else $error("transaction accepted during peak work");
   a_now_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_now_ff) |-> rsp_pv_ff) else $error("peak_now without peak_valid");
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import ptpid_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [31:0] command;
      logic signed [31:0] peak;
      logic               valid;
      logic               now;
   } paddle_result_type;

   // Bit-accurate copy of the controller: registers, runtime state and the
   // queue of responses still owed by the block.
   class paddle_scoreboard;
      logic signed [31:0] gain_p = 65536, gain_i = 0, gain_d = 0, target = 65536;
      logic signed [31:0] low = 0, high = 65536;
      logic [30:0]        period = 655;
      logic signed [31:0] prev_vel, peak;
      bit                 vel_seen, peak_valid, err_valid, peak_seen;
      longint             integral, prev_err;
      logic [31:0]        ticks;
      logic signed [31:0] held;
      paddle_result_type  owed[$];
      int failures = 0, n_items = 0, n_peaks = 0, n_clears = 0;

      function new();
         clear_state();
      endfunction

      function longint midpoint();
         longint s;
         s = longint'(low) + longint'(high);
         return s >>> 1;
      endfunction

      function void clear_state();
         prev_vel = 0; vel_seen = 0; peak = 0; peak_valid = 0;
         integral = 0; prev_err = 0; err_valid = 0; ticks = 0; peak_seen = 0;
         held = 32'(midpoint());
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] data);
         case (idx)
            REG_GAIN_P: gain_p = data;
            REG_GAIN_I: gain_i = data;
            REG_GAIN_D: gain_d = data;
            REG_TARGET: target = data;
            REG_LOW:    low = data;
            REG_HIGH:   high = data;
            REG_PERIOD: period = data[30:0];
            default: ;
         endcase
      endfunction

      function void update_command(logic signed [31:0] pos);
         longint err, deriv, diff;
         longint unsigned intv, q, amag;
         wide_type acc, term, imax, imin;
         bit have;
         imax = (wide_type'(1) <<< 47) - 1;
         imin = -imax - 1;
         err = longint'(target) - longint'(pos);
         intv = longint'(ticks) * longint'({1'b0, period});
         have = peak_seen && intv != 0;
         deriv = 0;
         peak = pos;
         peak_valid = 1;
         if (have) begin
            term = (wide_type'(err) * $signed({64'd0, intv})) >>> 16;
            if (term > imax) term = imax;
            if (term < imin) term = imin;
            term = term + wide_type'(integral);
            if (term > imax) term = imax;
            if (term < imin) term = imin;
            integral = longint'(term);
         end
         if (have && err_valid) begin
            diff = err - prev_err;
            amag = diff < 0 ? -diff : diff;
            q = (amag << 16) / intv;
            deriv = diff < 0 ? -longint'(q) : longint'(q);
         end
         acc = wide_type'(longint'(gain_p)) * wide_type'(err)
               + wide_type'(longint'(gain_i)) * wide_type'(integral)
               + wide_type'(longint'(gain_d)) * wide_type'(deriv);
         acc = (acc >>> 16) + wide_type'(midpoint());
         if (acc < wide_type'(longint'(low))) acc = wide_type'(longint'(low));
         else if (acc > wide_type'(longint'(high))) acc = wide_type'(longint'(high));
         held = acc[31:0];
         prev_err = err;
         err_valid = 1;
         ticks = 0;
         peak_seen = 1;
      endfunction

      function void note_request(logic cmd, logic signed [31:0] pos,
                                 logic signed [31:0] vel);
         paddle_result_type r;
         bit now;
         now = 0;
         n_items++;
         if (cmd == CMD_CLEAR) begin
            clear_state();
            n_clears++;
         end else begin
            if (vel_seen && prev_vel > 0 && vel <= 0) begin
               update_command(pos);
               now = 1;
               n_peaks++;
            end
            prev_vel = vel;
            vel_seen = 1;
            if (ticks != 32'hFFFF_FFFF) ticks++;
         end
         r.command = held;
         r.peak = peak_valid ? peak : 32'sd0;
         r.valid = peak_valid;
         r.now = now;
         owed.push_back(r);
      endfunction

      function void check_result(paddle_result_type act);
         paddle_result_type e;
         if (owed.size() == 0) begin
            $error("response with nothing outstanding: %p", act);
            failures++;
            return;
         end
         e = owed.pop_front();
         if (act.command !== e.command) begin
            $error("paddle_command expected %0d got %0d", e.command, act.command);
            failures++;
         end
         if (act.peak !== e.peak) begin
            $error("peak_height expected %0d got %0d", e.peak, act.peak);
            failures++;
         end
         if (act.valid !== e.valid) begin
            $error("peak_valid expected %0b got %0b", e.valid, act.valid);
            failures++;
         end
         if (act.now !== e.now) begin
            $error("peak_now expected %0b got %0b", e.now, act.now);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = CMD_TICK;
   logic signed [31:0] req_position = '0;
   logic signed [31:0] req_velocity = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_paddle_command, rsp_peak_height;
   logic rsp_peak_valid, rsp_peak_now;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   paddle_scoreboard sb = new();
   int cycles = 0;
   int stall_pct = 0;
   int max_gap = 3;

   always #2 clock = ~clock;

   peak_triggered_pid_controller_unit i_dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[peak_triggered_pid_controller_unit] ERROR");
         $finish;
      end
   end

   // The receiver switches between free flow, light and heavy back-pressure.
   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_pct <= $urandom_range(0, 3) * 25;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_command, req_position, req_velocity);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_paddle_command, rsp_peak_height, rsp_peak_valid,
                          rsp_peak_now});
   end

   int burst_left = 0;

   task automatic send(logic cmd, logic [31:0] pos, logic [31:0] vel);
      int gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_position <= pos;
      req_velocity <= vel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
         // Valid drops only for a real gap, so it never toggles within one step.
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] regs[7]);
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= regs[i];
         sb.set_register(i[2:0], regs[i]);
         @(posedge clock);
      end
      // An unknown index must leave every register alone.
      csr_index <= REG_UNUSED;
      csr_data <= $urandom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_velocity();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return $urandom_range(1, 1 << 20);
      if (pick < 55) return 32'd0;
      if (pick < 90) return -$urandom_range(1, 1 << 20);
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_position(logic [31:0] tgt);
      if ($urandom_range(0, 9) < 7) return tgt + $urandom_range(0, 1 << 19) - (1 << 18);
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_gain(int phase);
      if (phase == 1) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return $urandom_range(0, 1 << 19) - (1 << 18);
   endfunction

   initial begin
      logic [31:0] regs[7];
      logic [31:0] a, b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset defaults, first peak, extremes, zero velocity, clear.
      send(CMD_TICK, 32'h0001_0000, 32'h0000_1000);
      send(CMD_TICK, 32'h0002_0000, 32'd0);
      send(CMD_TICK, 32'h0000_8000, 32'h7FFF_FFFF);
      send(CMD_TICK, 32'h8000_0000, 32'h8000_0000);
      send(CMD_TICK, 32'h7FFF_FFFF, 32'd1);
      send(CMD_TICK, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_TICK, 32'd0, 32'd5);
      send(CMD_TICK, 32'h8000_0000, 32'd0);
      drain();
      regs = '{32'h0002_0000, 32'h0000_4000, 32'h0000_1000, 32'h0001_0000,
               32'hFFFF_0000, 32'h0002_0000, 32'd0};
      write_all(regs);
      // With no tick period every peak behaves like the first one.
      for (int i = 0; i < 6; i++) send(CMD_TICK, rand_position(32'h0001_0000),
                                       (i % 2 == 0) ? 32'h0000_8000 : 32'hFFFF_8000);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         regs[REG_GAIN_P] = rand_gain(phase);
         regs[REG_GAIN_I] = rand_gain(phase);
         regs[REG_GAIN_D] = rand_gain(phase);
         regs[REG_TARGET] = (phase == 1) ? 32'h8000_0000 : $urandom_range(0, 1 << 20);
         a = $urandom;
         b = $urandom;
         case (phase)
            1: begin a = 32'h8000_0000; b = 32'h7FFF_FFFF; end
            2: begin if ($signed(a) < $signed(b)) {a, b} = {b, a}; end
            3: begin a = 32'h7FFF_FFFF; b = 32'h8000_0000; end
            default: begin if ($signed(a) > $signed(b)) {a, b} = {b, a}; end
         endcase
         regs[REG_LOW] = a;
         regs[REG_HIGH] = b;
         case (phase)
            4: regs[REG_PERIOD] = 32'h7FFF_FFFF;
            5: regs[REG_PERIOD] = 32'd1;
            6: regs[REG_PERIOD] = 32'd0;
            default: regs[REG_PERIOD] = $urandom_range(1, 1 << 18);
         endcase
         write_all(regs);
         max_gap = (phase == 3) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < 75; i++)
            send($urandom_range(0, 99) < 3 ? CMD_CLEAR : CMD_TICK,
                 rand_position(regs[REG_TARGET]), rand_velocity());
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d transactions over 9 register settings: %0d peaks, %0d clears.",
               sb.n_items, sb.n_peaks, sb.n_clears);
      if (sb.failures == 0 && sb.owed.size() == 0)
         $display("[peak_triggered_pid_controller_unit] OK");
      else
         $display("[peak_triggered_pid_controller_unit] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/ptpid_pkg.sv
rtl/ptpid_serial_mul.sv
rtl/peak_triggered_pid_controller_unit.sv
dv/tb_top.sv
